// File: hw/rtl/ctaphid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ctaphid_pkg;

  // report framing
  localparam int unsigned REPORT_BYTES      = 64;
  localparam int unsigned POS_W             = $clog2(REPORT_BYTES);
  localparam int unsigned MAX_CONTINUATIONS = 128;
  localparam int unsigned INIT_HEADER_BYTES = 7;

  localparam logic [7:0] CMD_KEEPALIVE = 8'hbb;
  localparam logic [7:0] CMD_ERROR     = 8'hbf;

  // item modes
  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  // result status codes
  localparam logic [2:0] ST_RECEIVING = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_LENGTH    = 3'd2;
  localparam logic [2:0] ST_DEV_ERROR = 3'd3;
  localparam logic [2:0] ST_BAD_SEQ   = 3'd4;
  localparam logic [2:0] ST_TIMEOUT   = 3'd5;

  // register map
  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_CHANNEL_ID  = 2'd0;
  localparam logic [1:0] REG_EXPECTED    = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;
  localparam logic [1:0] REG_TIMEOUT     = 2'd3;

  localparam logic [31:0] RST_CHANNEL_ID  = 32'hffff_ffff;
  localparam logic [7:0]  RST_EXPECTED    = 8'd144;
  localparam logic [12:0] RST_MAX_PAYLOAD = 13'd7609;
  localparam logic [15:0] RST_TIMEOUT     = 16'd60000;

  typedef struct packed {
    logic [31:0] channel_id;
    logic [7:0]  accept_cmd;
    logic [12:0] max_payload;
    logic [15:0] time_budget;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       first_of_report;
    logic [7:0] report_byte;
  } item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] payload_byte;
    logic       last;
    logic [2:0] status;
    logic [7:0] device_error_code;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/ctaphid_message_reassembler.sv
`timescale 1ns / 1ps
`default_nettype none
// CTAPHID response reassembler. Feed 64-byte HID reports one word per cycle
// (mode 0, first_of_report marks byte 0), millisecond ticks (mode 1) and a
// start word (mode 2) that arms reception. One result per payload byte
// leaves in message order; the last byte's result, or else a result of its
// own, has last set and a status: complete, length too large, device error,
// bad sequence or timeout. After that the block ignores traffic until the
// next start. Each word passes the input register, then the result register;
// a new word is accepted every cycle unless the output is stalled. The user
// writes registers over APB port only while idle; the block does not check.
module ctaphid_message_reassembler (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      mode,
  input  wire logic                            first_of_report,
  input  wire logic [7:0]                      report_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 data_valid,
  output logic [7:0]                           payload_byte,
  output logic                                 last,
  output logic [2:0]                           status,
  output logic [7:0]                           device_error_code,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ctaphid_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import ctaphid_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_q_valid;
  result_t res;
  result_t out_q;
  logic    res_valid;
  logic    out_free;
  logic    fire;
  logic    in_take;

  assign out_free = !out_valid || !out_stall;
  assign fire     = in_q_valid && out_free;
  assign in_stall = in_q_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  ctaphid_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ctaphid_frame_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (in_q),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q <= '{mode: mode, first_of_report: first_of_report, report_byte: report_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign data_valid        = out_q.data_valid;
  assign payload_byte      = out_q.payload_byte;
  assign last              = out_q.last;
  assign status            = out_q.status;
  assign device_error_code = out_q.device_error_code;

endmodule
`default_nettype wire

// File: hw/rtl/ctaphid_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module ctaphid_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ctaphid_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output ctaphid_pkg::cfg_t                  cfg
);
  import ctaphid_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_id  <= RST_CHANNEL_ID;
      cfg.accept_cmd  <= RST_EXPECTED;
      cfg.max_payload <= RST_MAX_PAYLOAD;
      cfg.time_budget <= RST_TIMEOUT;
    end else if (wr_en) begin
      case (reg_sel)
        REG_CHANNEL_ID:  cfg.channel_id  <= pwdata;
        REG_EXPECTED:    cfg.accept_cmd  <= pwdata[7:0];
        REG_MAX_PAYLOAD: cfg.max_payload <= pwdata[12:0];
        REG_TIMEOUT:     cfg.time_budget <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CHANNEL_ID:  prdata = cfg.channel_id;
      REG_EXPECTED:    prdata = {24'd0, cfg.accept_cmd};
      REG_MAX_PAYLOAD: prdata = {19'd0, cfg.max_payload};
      REG_TIMEOUT:     prdata = {16'd0, cfg.time_budget};
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/ctaphid_frame_core.sv
`timescale 1ns / 1ps
`default_nettype none
module ctaphid_frame_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire ctaphid_pkg::item_t item,
  input  wire ctaphid_pkg::cfg_t  cfg,
  output logic                    res_valid,
  output ctaphid_pkg::result_t    res
);
  import ctaphid_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_INIT, PH_CONT} phase_t;
  typedef enum logic [1:0] {ACT_IGNORE, ACT_COPY, ACT_ERROR, ACT_LENGTH} action_t;

  phase_t            phase, phase_next;
  action_t           frame_action, frame_action_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [31:0]       header_channel, header_channel_next;
  logic [7:0]        length_high, length_high_next;
  logic [12:0]       declared_total, declared_total_next;
  logic [12:0]       bytes_copied, bytes_copied_next;
  logic [7:0]        next_sequence, next_sequence_next;
  logic [15:0]       time_left, time_left_next;

  logic [POS_W-1:0]  pos;
  logic [7:0]        b;
  logic [15:0]       total;
  logic [12:0]       copied_inc;
  logic              bad_seq;

  assign b          = item.report_byte;
  assign pos        = item.first_of_report ? '0 : byte_position;
  assign total      = {length_high, b};
  assign copied_inc = bytes_copied + 13'd1;
  assign bad_seq    = b[7] || ({1'b0, b} >= 9'(MAX_CONTINUATIONS)) || (b != next_sequence);

  always_comb begin
    phase_next          = phase;
    frame_action_next   = frame_action;
    byte_position_next  = byte_position;
    header_channel_next = header_channel;
    length_high_next    = length_high;
    declared_total_next = declared_total;
    bytes_copied_next   = bytes_copied;
    next_sequence_next  = next_sequence;
    time_left_next      = time_left;
    res_valid           = 1'b0;
    res                 = '0;

    case (item.mode)
      MODE_START: begin
        phase_next          = PH_INIT;
        frame_action_next   = ACT_IGNORE;
        byte_position_next  = '0;
        declared_total_next = '0;
        bytes_copied_next   = '0;
        next_sequence_next  = '0;
        length_high_next    = '0;
        time_left_next      = cfg.time_budget;
      end
      MODE_TICK: begin
        if (phase != PH_IDLE) begin
          if (time_left <= 16'd1) begin
            time_left_next    = '0;
            phase_next        = PH_IDLE;
            frame_action_next = ACT_IGNORE;
            res_valid         = 1'b1;
            res.last          = 1'b1;
            res.status        = ST_TIMEOUT;
          end else begin
            time_left_next = time_left - 16'd1;
          end
        end
      end
      MODE_BYTE: begin
        byte_position_next = (pos == POS_W'(REPORT_BYTES - 1)) ? '0 : pos + POS_W'(1);
        if (phase != PH_IDLE) begin
          if (pos < POS_W'(4)) begin
            // channel id arrives big endian in bytes 0..3
            header_channel_next = {header_channel[23:0], b};
            if (pos == '0) frame_action_next = ACT_IGNORE;
          end else if (pos == POS_W'(4)) begin
            frame_action_next = ACT_IGNORE;
            if (header_channel == cfg.channel_id && b != CMD_KEEPALIVE) begin
              if (phase == PH_INIT) begin
                if (b == CMD_ERROR) frame_action_next = ACT_ERROR;
                else if (b == cfg.accept_cmd) frame_action_next = ACT_LENGTH;
              end else if (bad_seq) begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res.last   = 1'b1;
                res.status = ST_BAD_SEQ;
              end else begin
                next_sequence_next = next_sequence + 8'd1;
                frame_action_next  = ACT_COPY;
              end
            end
          end else begin
            case (frame_action)
              ACT_ERROR: begin
                if (pos == POS_W'(INIT_HEADER_BYTES)) begin
                  phase_next            = PH_IDLE;
                  frame_action_next     = ACT_IGNORE;
                  res_valid             = 1'b1;
                  res.last              = 1'b1;
                  res.status            = ST_DEV_ERROR;
                  res.device_error_code = b;
                end
              end
              ACT_LENGTH: begin
                if (pos == POS_W'(5)) begin
                  length_high_next = b;
                end else if (total > {3'd0, cfg.max_payload}) begin
                  phase_next        = PH_IDLE;
                  frame_action_next = ACT_IGNORE;
                  res_valid         = 1'b1;
                  res.last          = 1'b1;
                  res.status        = ST_LENGTH;
                end else begin
                  declared_total_next = total[12:0];
                  bytes_copied_next   = '0;
                  if (total == 16'd0) begin
                    phase_next        = PH_IDLE;
                    frame_action_next = ACT_IGNORE;
                    res_valid         = 1'b1;
                    res.last          = 1'b1;
                    res.status        = ST_COMPLETE;
                  end else begin
                    phase_next        = PH_CONT;
                    frame_action_next = ACT_COPY;
                  end
                end
              end
              ACT_COPY: begin
                if (bytes_copied < declared_total) begin
                  bytes_copied_next = copied_inc;
                  res_valid         = 1'b1;
                  res.data_valid    = 1'b1;
                  res.payload_byte  = b;
                  if (copied_inc == declared_total) begin
                    phase_next        = PH_IDLE;
                    frame_action_next = ACT_IGNORE;
                    res.last          = 1'b1;
                    res.status        = ST_COMPLETE;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      frame_action   <= ACT_IGNORE;
      byte_position  <= '0;
      header_channel <= '0;
      length_high    <= '0;
      declared_total <= '0;
      bytes_copied   <= '0;
      next_sequence  <= '0;
      time_left      <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      frame_action   <= frame_action_next;
      byte_position  <= byte_position_next;
      header_channel <= header_channel_next;
      length_high    <= length_high_next;
      declared_total <= declared_total_next;
      bytes_copied   <= bytes_copied_next;
      next_sequence  <= next_sequence_next;
      time_left      <= time_left_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ctaphid_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ctaphid_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       data_valid,
  input wire logic [7:0] payload_byte,
  input wire logic       last,
  input wire logic [2:0] status,
  input wire logic [7:0] device_error_code
);
  import ctaphid_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(status)
      && $stable(last) && $stable(data_valid) && $stable(device_error_code))
    else $error("result changed while stalled");

  // only a plain receiving result goes without last
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (status != ST_RECEIVING)))
    else $error("last does not match status");

  // payload only rides on receiving or complete results
  a_data_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> (status == ST_RECEIVING || status == ST_COMPLETE))
    else $error("payload on a terminating error result");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DEV_ERROR |-> device_error_code == 8'd0)
    else $error("error code without device error");

  a_no_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> payload_byte == 8'd0 && status != ST_RECEIVING)
    else $error("empty result carries a byte or no terminal status");

endmodule

bind ctaphid_message_reassembler ctaphid_checker u_checker (.*);
`default_nettype wire
